### rtl/lpbc_pkg.sv
// ----------------------------------------------------------------------------
// lpbc_pkg
// Shared types and constants of the LRU page buffer controller: field widths,
// opcodes, result codes, register map and controller/datapath interface.
// ----------------------------------------------------------------------------
package lpbc_pkg;

  // field widths
  localparam int OPCODE_W   = 3;
  localparam int FILE_W     = 8;
  localparam int PAGE_W     = 16;
  localparam int TAG_W      = FILE_W + PAGE_W;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int STAMP_W    = 32;
  localparam int ACT_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ACTIVE_SLOTS = 1'b0;   // paddr[2] of the register
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_READ  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FLUSH = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PIN   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_UNPIN = 3'd4;

  // result codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALL_PINNED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } lpbc_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, restart scan
    logic scan_rd;   // read the slot at the scan pointer
    logic commit;    // apply the decision, load the result register
  } lpbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;  // every occupied slot has been read
    logic out_free;  // result register can take a new beat
  } lpbc_stat_t;

endpackage

### rtl/lpbc_ram.sv
// ----------------------------------------------------------------------------
// lpbc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lpbc_ctrl.sv
// ----------------------------------------------------------------------------
// lpbc_ctrl
// Request sequencer: accepts a request, walks the occupied slots through the
// datapath, waits for the last compare and commits once the result register
// is free.
// ----------------------------------------------------------------------------
module lpbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpbc_pkg::lpbc_stat_t stat_i,
  output lpbc_pkg::lpbc_cmd_t  cmd_o
);
  import lpbc_pkg::*;

  lpbc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        // the last slot read is compared in the scan end cycle
        if (stat_i.scan_end) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        // spare cycle, match and victim registers already settled
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/lpbc_datapath.sv
// ----------------------------------------------------------------------------
// lpbc_datapath
// Tag and stamp memories, pin and dirty bits, slot scan with tag match and
// LRU victim tracking, replacement decision and the result register.
// ----------------------------------------------------------------------------
module lpbc_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lpbc_pkg::lpbc_cmd_t            cmd_i,
  output lpbc_pkg::lpbc_stat_t           stat_o,
  input  logic [lpbc_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic                           cfg_we_i,
  input  logic [lpbc_pkg::ACT_W-1:0]     cfg_wdata_i,
  output logic [lpbc_pkg::ACT_W-1:0]     active_slots_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lpbc_pkg::OUT_DATA_W-1:0] out_data_o
);
  import lpbc_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int OCW = $clog2(SLOTS + 1);
  localparam int CW  = (OCW > ACT_W) ? OCW : ACT_W;
  localparam int SXW = (SW > SLOT_OUT_W) ? SW : SLOT_OUT_W;
  localparam logic [OCW-1:0] SLOTS_C = OCW'(SLOTS);

  // request and configuration
  logic [OPCODE_W-1:0] op_q;
  logic [FILE_W-1:0]   file_q;
  logic [PAGE_W-1:0]   page_q;
  logic [ACT_W-1:0]    active_q;

  // slot state
  logic [OCW-1:0]     occ_q, occ_d;
  logic [SLOTS-1:0]   pinned_q, pinned_d;
  logic [SLOTS-1:0]   dirty_q, dirty_d;
  logic [STAMP_W-1:0] counter_q, counter_d;

  // scan
  logic [OCW-1:0]     scan_idx_q;
  logic               cmp_vld_q;
  logic [SW-1:0]      cmp_idx_q;
  logic               match_found_q;
  logic [SW-1:0]      match_idx_q;
  logic               vic_found_q;
  logic [SW-1:0]      vic_idx_q;
  logic [STAMP_W-1:0] vic_stamp_q;
  logic [TAG_W-1:0]   vic_tag_q;

  // memories
  logic [TAG_W-1:0]   tag_rdata;
  logic [STAMP_W-1:0] stamp_rdata;
  logic               tag_we, stamp_we;

  // decision
  logic               fill_ok;
  logic               succ;
  logic [SW-1:0]      slot;
  logic [SXW-1:0]     slot_ext;
  logic [STATUS_W-1:0] status;
  logic               fetch, wb;
  logic [FILE_W-1:0]  wb_file;
  logic [PAGE_W-1:0]  wb_page;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i[OPCODE_W-1:0];
      file_q <= in_data_i[OPCODE_W +: FILE_W];
      page_q <= in_data_i[OPCODE_W+FILE_W +: PAGE_W];
    end
  end

  // active slot register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  assign active_slots_o = active_q;

  // tag and stamp memories
  lpbc_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (slot),
    .wdata_i ({page_q, file_q}),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_idx_q[SW-1:0]),
    .rdata_o (tag_rdata)
  );

  lpbc_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (slot),
    .wdata_i (counter_q),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_idx_q[SW-1:0]),
    .rdata_o (stamp_rdata)
  );

  // scan pointer and compare stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q    <= '0;
      cmp_vld_q     <= 1'b0;
      match_found_q <= 1'b0;
      vic_found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        scan_idx_q    <= '0;
        match_found_q <= 1'b0;
        vic_found_q   <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_idx_q <= scan_idx_q + OCW'(1);
        end
        if (cmp_vld_q && !match_found_q && tag_rdata == {page_q, file_q}) begin
          match_found_q <= 1'b1;
        end
        if (cmp_vld_q && !pinned_q[cmp_idx_q] &&
            (!vic_found_q || stamp_rdata < vic_stamp_q)) begin
          vic_found_q <= 1'b1;
        end
      end
    end
  end

  // compare payload: first match and oldest unpinned slot
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_idx_q[SW-1:0];
    if (cmp_vld_q && !match_found_q && tag_rdata == {page_q, file_q}) begin
      match_idx_q <= cmp_idx_q;
    end
    if (cmp_vld_q && !pinned_q[cmp_idx_q] &&
        (!vic_found_q || stamp_rdata < vic_stamp_q)) begin
      vic_idx_q   <= cmp_idx_q;
      vic_stamp_q <= stamp_rdata;
      vic_tag_q   <= tag_rdata;
    end
  end

  assign stat_o.scan_end = (scan_idx_q == occ_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // free slot available: occupied below max(1, min(active, SLOTS))
  assign fill_ok = (occ_q != SLOTS_C) &&
                   ((CW'(occ_q) < CW'(active_q)) ||
                    (active_q == '0 && occ_q == '0));

  // replacement decision and state updates
  always_comb begin
    succ      = 1'b0;
    slot      = match_idx_q;
    status    = ST_NOT_PRESENT;
    fetch     = 1'b0;
    wb        = 1'b0;
    wb_file   = '0;
    wb_page   = '0;
    occ_d     = occ_q;
    pinned_d  = pinned_q;
    dirty_d   = dirty_q;
    counter_d = counter_q;
    tag_we    = 1'b0;
    stamp_we  = 1'b0;
    if (op_q == OP_READ || op_q == OP_WRITE) begin
      priority if (match_found_q) begin
        succ   = 1'b1;
        status = ST_HIT;
      end else if (fill_ok) begin
        succ   = 1'b1;
        slot   = occ_q[SW-1:0];
        status = ST_MISS;
        fetch  = 1'b1;
        occ_d  = occ_q + OCW'(1);
      end else if (vic_found_q) begin
        succ   = 1'b1;
        slot   = vic_idx_q;
        status = ST_MISS;
        fetch  = 1'b1;
        if (dirty_q[vic_idx_q]) begin
          wb      = 1'b1;
          wb_file = vic_tag_q[FILE_W-1:0];
          wb_page = vic_tag_q[FILE_W +: PAGE_W];
        end
      end else begin
        status = ST_ALL_PINNED;
      end
      if (succ) begin
        tag_we   = fetch;
        stamp_we = 1'b1;
        if (counter_q != '1) begin
          counter_d = counter_q + STAMP_W'(1);
        end
        if (op_q == OP_WRITE) begin
          dirty_d[slot] = 1'b1;
        end else if (fetch) begin
          dirty_d[slot] = 1'b0;
        end
      end
    end else if (op_q == OP_FLUSH || op_q == OP_PIN || op_q == OP_UNPIN) begin
      if (match_found_q) begin
        succ   = 1'b1;
        status = ST_HIT;
        if (op_q == OP_FLUSH) begin
          wb             = 1'b1;
          wb_file        = file_q;
          wb_page        = page_q;
          dirty_d[slot]  = 1'b0;
        end else begin
          pinned_d[slot] = (op_q == OP_PIN);
        end
      end
    end
    if (!succ) begin
      slot = '0;
    end
    tag_we   = tag_we && cmd_i.commit;
    stamp_we = stamp_we && cmd_i.commit;
  end

  assign slot_ext = SXW'(slot);

  // slot state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      pinned_q  <= '0;
      dirty_q   <= '0;
      counter_q <= '0;
    end else if (cmd_i.commit) begin
      occ_q     <= occ_d;
      pinned_q  <= pinned_d;
      dirty_q   <= dirty_d;
      counter_q <= counter_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {wb_page, wb_file, wb, fetch, slot_ext[SLOT_OUT_W-1:0], status};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/lru_page_buffer_controller.sv
// ----------------------------------------------------------------------------
// lru_page_buffer_controller
// Tag and LRU replacement controller for a pool of page buffer slots.
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | request beat: opcode, file id, page number
//  m_axis    | out       | result beat: status, slot, fetch, writeback page
//  apb       | in/out    | active_slots register at byte address 0
//
//  A request is accepted, then the occupied slots (at most SLOTS) are read
//  in turn on the single read port of the tag and stamp memories, the last
//  slot is compared, a spare state follows and the request is committed.
//  Reset (rst_ni, asynchronous) empties the pool; no clearing pass is run.
//  A result waits in the output register while the next request is taken;
//  its commit waits only if that register is still full.
// ----------------------------------------------------------------------------
module lru_page_buffer_controller #(
  parameter int SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request: [2:0] opcode, [10:3] file_id, [26:11] page_number
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lpbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // result: [1:0] status, [5:2] slot_index, [6] fetch_needed,
  // [7] writeback_needed, [15:8] writeback_file_id, [31:16] writeback_page_number
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lpbc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpbc_pkg::APB_AW-1:0]     paddr,
  input  logic [lpbc_pkg::APB_DW-1:0]     pwdata,
  output logic [lpbc_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import lpbc_pkg::*;

  lpbc_cmd_t        cmd;
  lpbc_stat_t       stat;
  logic             cfg_we;
  logic [ACT_W-1:0] active_slots;

  // register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SLOTS);
  assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ? APB_DW'(active_slots) : '0;

  // sequencer
  lpbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // slot state and decision
  lpbc_datapath #(.SLOTS(SLOTS)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_data_i      (s_axis_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[ACT_W-1:0]),
    .active_slots_o (active_slots),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

### rtl/lpbc_checker.sv
// ----------------------------------------------------------------------------
// lpbc_checker
// Port-level checks of the LRU page buffer controller, bound to the top.
// ----------------------------------------------------------------------------
module lpbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lpbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import lpbc_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed under stall");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // fetch only on a miss
  a_fetch_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_MISS |-> !m_axis_tdata[6])
    else $error("fetch without a miss");

  // writeback address zero when no writeback
  a_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[31:8] == '0)
    else $error("writeback address without writeback");

  // failed request reports nothing
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == ST_ALL_PINNED ||
                      m_axis_tdata[1:0] == ST_NOT_PRESENT) |->
    m_axis_tdata[31:2] == '0)
    else $error("failed request with slot or flags");

endmodule

bind lru_page_buffer_controller lpbc_checker u_lpbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU page buffer controller. A queue of page
// requests feeds a stream driver that sends beats in bursts with random gaps;
// a monitor stalls the result stream on its own pattern and compares every
// result beat, field by field, with the output of a behavioral predictor of
// the slot tags, pin and dirty bits, use stamps and LRU victim choice.
// The active_slots register is changed between phases, only while idle.
// ----------------------------------------------------------------------------
module tb;
  import lpbc_pkg::*;

  localparam int SLOTS        = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_TICKS = SLOTS + 8;
  localparam int RANDOM_ITEMS = 500;
  localparam int POOL_SIZE    = 32;
  localparam int MAX_PRINTS   = 40;

  // opcodes the block leaves undefined
  localparam logic [OPCODE_W-1:0] OP_RSV_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSV_MID   = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSV_LAST  = 3'd7;

  localparam logic [APB_AW-1:0] ACTIVE_ADDR = {REG_ACTIVE_SLOTS, 2'b00};

  // request beat, lowest field in the lowest bits
  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [FILE_W-1:0]   file_id;
    logic [OPCODE_W-1:0] opcode;
  } page_req_t;

  // result beat, laid out exactly as m_axis_tdata
  typedef struct packed {
    logic [PAGE_W-1:0]     wb_page;
    logic [FILE_W-1:0]     wb_file;
    logic                  writeback;
    logic                  fetch;
    logic [SLOT_OUT_W-1:0] slot;
    logic [STATUS_W-1:0]   status;
  } slot_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_STALLS
  } rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_AW-1:0]     paddr         = '0;
  logic [APB_DW-1:0]     pwdata        = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  lru_page_buffer_controller #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted pool state
  logic [ACT_W-1:0]   active_cfg = ACT_RESET;
  int                 occupied   = 0;
  logic [FILE_W-1:0]  file_tag  [SLOTS];
  logic [PAGE_W-1:0]  page_tag  [SLOTS];
  logic [STAMP_W-1:0] use_stamp [SLOTS];
  logic [SLOTS-1:0]   pinned     = '0;
  logic [SLOTS-1:0]   dirty      = '0;
  logic [STAMP_W-1:0] access_cnt = '0;

  page_req_t    page_requests[$];
  slot_result_t due_results[$];
  int           err_cnt   = 0;
  int           cycle_cnt = 0;
  bit           item_busy = 1'b0;

  // lookup, fill or evict, and the flag updates of one request
  function automatic slot_result_t resolve_request(page_req_t rq);
    slot_result_t res;
    int           slot;
    int           victim;
    int           eff;
    int           i;
    res        = '0;
    res.status = ST_NOT_PRESENT;
    slot       = -1;
    for (i = 0; i < occupied; i++) begin
      if (slot < 0 && file_tag[i] == rq.file_id && page_tag[i] == rq.page) slot = i;
    end
    eff = (active_cfg == 0) ? 1 : ((int'(active_cfg) > SLOTS) ? SLOTS : int'(active_cfg));
    if (rq.opcode == OP_READ || rq.opcode == OP_WRITE) begin
      if (slot >= 0) begin
        res.status = ST_HIT;
      end else if (occupied < eff) begin
        slot       = occupied;
        occupied   = occupied + 1;
        res.status = ST_MISS;
      end else begin
        // lru among unpinned occupied slots, lowest index on ties
        victim = -1;
        for (i = 0; i < occupied; i++) begin
          if (!pinned[i] && (victim < 0 || use_stamp[i] < use_stamp[victim])) victim = i;
        end
        slot = victim;
        if (slot >= 0) begin
          if (dirty[slot]) begin
            res.writeback = 1'b1;
            res.wb_file   = file_tag[slot];
            res.wb_page   = page_tag[slot];
            dirty[slot]   = 1'b0;
          end
          res.status = ST_MISS;
        end else begin
          res.status = ST_ALL_PINNED;
        end
      end
      if (slot >= 0) begin
        if (res.status == ST_MISS) begin
          file_tag[slot] = rq.file_id;
          page_tag[slot] = rq.page;
          res.fetch      = 1'b1;
        end
        // saturating access counter
        use_stamp[slot] = access_cnt;
        if (access_cnt != '1) access_cnt = access_cnt + 1'b1;
        if (rq.opcode == OP_WRITE) dirty[slot] = 1'b1;
        res.slot = SLOT_OUT_W'(slot);
      end
    end else if (rq.opcode == OP_FLUSH || rq.opcode == OP_PIN || rq.opcode == OP_UNPIN) begin
      if (slot >= 0) begin
        res.status = ST_HIT;
        res.slot   = SLOT_OUT_W'(slot);
        if (rq.opcode == OP_FLUSH) begin
          res.writeback = 1'b1;
          res.wb_file   = rq.file_id;
          res.wb_page   = rq.page;
          dirty[slot]   = 1'b0;
        end else begin
          pinned[slot] = (rq.opcode == OP_PIN);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (err_cnt < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  // cycle counter and timeout
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // request driver: bursts of beats with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  page_req_t   cur_req;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      item_busy = 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      // accepted beat goes to the predictor
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(resolve_request(cur_req));
        item_busy = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!item_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (page_requests.size() > 0) begin
          cur_req   = page_requests.pop_front();
          item_busy = 1'b1;
          nxt_valid = 1'b1;
          s_axis_tdata <= IN_DATA_W'(cur_req);
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // result monitor and receiver stall pattern
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t got;
    slot_result_t want;
    logic         nxt_ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = slot_result_t'(m_axis_tdata);
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat", m_axis_tdata, 0);
        end else begin
          want = due_results.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.slot != want.slot) report_mismatch("slot_index", got.slot, want.slot);
          if (got.fetch != want.fetch) report_mismatch("fetch_needed", got.fetch, want.fetch);
          if (got.writeback != want.writeback) begin
            report_mismatch("writeback_needed", got.writeback, want.writeback);
          end
          if (got.wb_file != want.wb_file) begin
            report_mismatch("writeback_file_id", got.wb_file, want.wb_file);
          end
          if (got.wb_page != want.wb_page) begin
            report_mismatch("writeback_page_number", got.wb_page, want.wb_page);
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN: begin
          nxt_ready = 1'b1;
        end
        RX_COIN: begin
          nxt_ready = 1'($urandom_range(0, 1));
        end
        default: begin
          if (stall_left > 0) begin
            nxt_ready = 1'b0;
            stall_left--;
          end else begin
            nxt_ready = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
          end
        end
      endcase
      m_axis_tready <= nxt_ready;
    end
  end

  // stimulus helpers
  logic [TAG_W-1:0] addr_pool[POOL_SIZE];

  task automatic queue_req(logic [OPCODE_W-1:0] op, logic [TAG_W-1:0] addr);
    page_req_t rq;
    rq.opcode  = op;
    rq.file_id = addr[TAG_W-1:PAGE_W];
    rq.page    = addr[PAGE_W-1:0];
    page_requests.push_back(rq);
  endtask

  // wait until every request has been answered
  task automatic settle();
    while (page_requests.size() != 0 || item_busy || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // register write, then read back
  task automatic set_active(logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACTIVE_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    active_cfg = value[ACT_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata != APB_DW'(active_cfg)) report_mismatch("active_slots readback", prdata, active_cfg);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwdata  <= '0;
  endtask

  // random phase: mostly a small working set so that hits and evictions occur
  task automatic queue_random_phase(int n);
    int                  ws;
    int unsigned         pick;
    logic [OPCODE_W-1:0] op;
    logic [TAG_W-1:0]    addr;
    ws = $urandom_range(2, 24);
    for (int k = 0; k < 4; k++) addr_pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_W'($urandom);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_READ;
      else if (pick < 65) op = OP_WRITE;
      else if (pick < 75) op = OP_FLUSH;
      else if (pick < 83) op = OP_PIN;
      else if (pick < 95) op = OP_UNPIN;
      else op = OPCODE_W'($urandom_range(OP_RSV_FIRST, OP_RSV_LAST));
      if ($urandom_range(0, 9) == 0) addr = TAG_W'($urandom);
      else addr = addr_pool[$urandom_range(0, ws - 1)];
      queue_req(op, addr);
    end
  endtask

  // main sequence
  localparam logic [TAG_W-1:0] PG_A = {8'h00, 16'h0000};
  localparam logic [TAG_W-1:0] PG_B = {8'hFF, 16'hFFFF};
  localparam logic [TAG_W-1:0] PG_C = {8'hA5, 16'h5A5A};
  localparam logic [TAG_W-1:0] PG_D = {8'h5A, 16'hA5A5};
  localparam logic [TAG_W-1:0] PG_E = {8'h01, 16'h8000};

  initial begin
    int          sent;
    int          n;
    int unsigned sel;
    int          waited;
    logic [APB_DW-1:0] value;
    sent = 0;
    for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = TAG_W'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // two slots: fill, hit, clean and dirty eviction
    set_active(32'd2);
    queue_req(OP_READ, PG_A);
    queue_req(OP_READ, PG_A);
    queue_req(OP_WRITE, PG_B);
    queue_req(OP_READ, PG_C);
    queue_req(OP_READ, PG_D);
    // flush of a clean page still reports writeback
    queue_req(OP_FLUSH, PG_C);
    // every slot pinned, then absent pages
    queue_req(OP_PIN, PG_C);
    queue_req(OP_PIN, PG_D);
    queue_req(OP_READ, PG_E);
    queue_req(OP_WRITE, PG_E);
    queue_req(OP_UNPIN, PG_E);
    queue_req(OP_FLUSH, PG_E);
    queue_req(OP_UNPIN, PG_C);
    queue_req(OP_WRITE, PG_E);
    queue_req(OP_FLUSH, PG_E);
    // undefined opcodes on a resident page
    queue_req(OP_RSV_FIRST, PG_D);
    queue_req(OP_RSV_MID, PG_D);
    queue_req(OP_RSV_LAST, PG_D);
    queue_req(OP_READ, PG_D);
    settle();

    // zero acts as one, occupied slots above the active count
    set_active(32'd0);
    queue_req(OP_READ, PG_A);
    queue_req(OP_UNPIN, PG_D);
    queue_req(OP_WRITE, PG_B);
    settle();

    // above the slot count, upper data bits ignored
    set_active(32'hFFFF_FFFF);
    queue_req(OP_READ, PG_C);
    queue_req(OP_WRITE, PG_A);
    queue_req(OP_READ, PG_B);
    settle();

    // random phases over a spread of active counts
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 5);
      if (sel == 0) value = 32'd0;
      else if (sel == 1) value = 32'd1;
      else if (sel == 2) value = 32'd16;
      else if (sel == 3) value = $urandom_range(17, 31);
      else value = $urandom_range(2, 15);
      if ($urandom_range(0, 3) == 0) value[APB_DW-1:ACT_W] = (APB_DW-ACT_W)'($urandom);
      set_active(value);
      n = $urandom_range(30, 70);
      queue_random_phase(n);
      sent += n;
      settle();
    end

    // final drain with a bound
    while (page_requests.size() != 0 || item_busy) @(posedge clk_i);
    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_TICKS * 4) @(posedge clk_i);
    if (due_results.size() != 0) report_mismatch("missing result beats", due_results.size(), 0);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### lru_page_buffer_controller.f
rtl/lpbc_pkg.sv
rtl/lpbc_ram.sv
rtl/lpbc_ctrl.sv
rtl/lpbc_datapath.sv
rtl/lru_page_buffer_controller.sv
rtl/lpbc_checker.sv
verif/tb.sv
